/* src/b24k_pkg.sv */
// Shared types, constants and the character classifier for the base-24 key decoder.
// No dependencies; every other file of the block imports this package.
package b24k_pkg;

    // Key geometry and value layout
    localparam int unsigned KEY_LENGTH      = 25;
    localparam int unsigned VALUE_BYTES_DEF = 16;
    localparam int unsigned COUNT_W         = 5;
    localparam int unsigned DIGIT_W         = 5;
    localparam int unsigned N_FLAG_BIT      = 115;
    localparam int unsigned LOW_W           = 64;
    localparam int unsigned HIGH_W          = 52;
    localparam int unsigned OUT_DATA_W      = 120;
    localparam int unsigned STATUS_W        = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

    // Character codes the classifier tests for
    localparam logic [7:0] CHAR_DASH   = 8'h2D;
    localparam logic [7:0] CHAR_N      = 8'h4E;
    localparam logic [7:0] CHAR_LOW_A  = 8'h61;
    localparam logic [7:0] CHAR_LOW_Z  = 8'h7A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    // What one key character means to the accumulator
    typedef enum logic [1:0] {
        KIND_SKIP,
        KIND_N,
        KIND_DIGIT,
        KIND_BAD
    } char_kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_LENGTH   = 2'd1,
        STATUS_BAD_CHAR = 2'd2
    } status_t;

    typedef struct packed {
        char_kind_t         kind;
        logic [DIGIT_W-1:0] digit;
    } char_class_t;

    // One classified beat as it waits in the queue
    typedef struct packed {
        char_kind_t         kind;
        logic [DIGIT_W-1:0] digit;
        logic               last;
    } char_entry_t;

    // Map a byte to its class; letters a..z are folded to upper case first
    function automatic char_class_t classify_char(input logic [7:0] raw);
        logic [7:0]  c;
        char_class_t res;
        c         = raw;
        res.kind  = KIND_DIGIT;
        res.digit = '0;
        if (raw >= CHAR_LOW_A && raw <= CHAR_LOW_Z) begin
            c = raw - CASE_OFFSET;
        end
        if (raw == CHAR_DASH) begin
            res.kind = KIND_SKIP;
        end else if (c == CHAR_N) begin
            res.kind = KIND_N;
        end else begin
            unique case (c)
                "B":     res.digit = 5'd0;
                "C":     res.digit = 5'd1;
                "D":     res.digit = 5'd2;
                "F":     res.digit = 5'd3;
                "G":     res.digit = 5'd4;
                "H":     res.digit = 5'd5;
                "J":     res.digit = 5'd6;
                "K":     res.digit = 5'd7;
                "M":     res.digit = 5'd8;
                "P":     res.digit = 5'd9;
                "Q":     res.digit = 5'd10;
                "R":     res.digit = 5'd11;
                "T":     res.digit = 5'd12;
                "V":     res.digit = 5'd13;
                "W":     res.digit = 5'd14;
                "X":     res.digit = 5'd15;
                "Y":     res.digit = 5'd16;
                "2":     res.digit = 5'd17;
                "3":     res.digit = 5'd18;
                "4":     res.digit = 5'd19;
                "6":     res.digit = 5'd20;
                "7":     res.digit = 5'd21;
                "8":     res.digit = 5'd22;
                "9":     res.digit = 5'd23;
                default: res.kind  = KIND_BAD;
            endcase
        end
        return res;
    endfunction

endpackage

/* src/b24k_front.sv */
// Input side of the key decoder: takes key character beats and classifies them.
// Depends on b24k_pkg; feeds b24k_queue.
module b24k_front (
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] key_char
    input  logic                 s_tlast,   // last_char
    input  logic                 q_full,
    output logic                 q_push,
    output b24k_pkg::char_entry_t q_entry
);
    import b24k_pkg::*;

    char_class_t cls;

    // Classify the incoming beat and push it whenever the queue has room
    always_comb
    begin
        cls           = classify_char(s_tdata);
        s_tready      = !q_full;
        q_push        = s_tvalid && !q_full;
        q_entry.kind  = cls.kind;
        q_entry.digit = cls.digit;
        q_entry.last  = s_tlast;
    end

endmodule

/* src/b24k_queue.sv */
// Two-entry queue of classified characters between the front and back of the decoder.
// Depends on b24k_pkg for the entry type.
module b24k_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  b24k_pkg::char_entry_t push_entry,
    output logic                  full,
    input  logic                  pop,
    output logic                  head_valid,
    output b24k_pkg::char_entry_t head_entry
);
    import b24k_pkg::*;

    char_entry_t slot_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_entry = slot_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed beat
    always_ff @(posedge clk)
    begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue occupancy out of range");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != 2'd0)
        else $error("pop from empty queue");
    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0 || count_reg == 2'd2) |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers disagree with occupancy");

endmodule

/* src/b24k_back.sv */
// Back end of the key decoder: base-24 accumulation, N marker, status and result register.
// Depends on b24k_pkg; takes beats from b24k_queue.
module b24k_back #(
    parameter int unsigned VALUE_BYTES = b24k_pkg::VALUE_BYTES_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  head_valid,
    input  b24k_pkg::char_entry_t                 head_entry,
    output logic                                  pop,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [b24k_pkg::OUT_DATA_W-1:0]       m_tdata,
    output logic [b24k_pkg::STATUS_W-1:0]         m_tuser
);
    import b24k_pkg::*;

    localparam int unsigned ACC_W = 8 * VALUE_BYTES;

    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [ACC_W-1:0]   radix_reg, radix_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               n_seen_reg, n_seen_next;
    logic               bad_reg, bad_next;
    logic               too_long_reg, too_long_next;
    logic               out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;
    status_t            out_status_reg, out_status_next;

    logic [ACC_W-1:0]         scaled;
    logic [ACC_W-1:0]         acc_x24;
    logic [ACC_W-1:0]         radix_x24;
    logic [ACC_W-1:0]         value;
    status_t                  status;
    logic                     counted;

    // Take a beat unless it ends a key and the result register is still held
    assign pop = head_valid && (!head_entry.last || !out_valid_reg || m_tready);

    assign acc_x24   = {acc_reg[ACC_W-5:0], 4'b0} + {acc_reg[ACC_W-4:0], 3'b0};
    assign radix_x24 = {radix_reg[ACC_W-5:0], 4'b0} + {radix_reg[ACC_W-4:0], 3'b0};
    assign counted   = (head_entry.kind != KIND_SKIP);

    // Scale the radix power by the character count, one shifted add per count bit
    always_comb
    begin
        scaled = '0;
        for (int i = 0; i < COUNT_W; i++)
        begin
            if (count_reg[i]) begin
                scaled = scaled + (radix_reg << i);
            end
        end
    end

    always_comb
    begin
        acc_next        = acc_reg;
        radix_next      = radix_reg;
        count_next      = count_reg;
        n_seen_next     = n_seen_reg;
        bad_next        = bad_reg;
        too_long_next   = too_long_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_data_next   = out_data_reg;
        out_status_next = out_status_reg;
        value           = '0;
        status          = STATUS_OK;

        // Accumulate one counted character
        if (pop && counted) begin
            if (count_reg == COUNT_MAX) begin
                too_long_next = 1'b1;
            end else begin
                if (head_entry.kind == KIND_N && !n_seen_reg) begin
                    n_seen_next = 1'b1;
                    acc_next    = acc_reg + scaled;
                end else if (head_entry.kind == KIND_DIGIT) begin
                    acc_next = acc_x24 + {{(ACC_W-DIGIT_W){1'b0}}, head_entry.digit};
                end else begin
                    bad_next = 1'b1;
                end
                radix_next = radix_x24;
                count_next = count_reg + 5'd1;
            end
        end

        // Close the key: grade it, load the result, clear state
        if (pop && head_entry.last) begin
            if (too_long_next || count_next != COUNT_W'(KEY_LENGTH)) begin
                status = STATUS_LENGTH;
            end else if (bad_next) begin
                status = STATUS_BAD_CHAR;
            end else begin
                status = STATUS_OK;
            end
            value             = acc_next;
            value[N_FLAG_BIT] = acc_next[N_FLAG_BIT] | n_seen_next;
            if (status == STATUS_OK) begin
                out_data_next = {3'b0, n_seen_next, value[N_FLAG_BIT:0]};
            end else begin
                out_data_next = '0;
            end
            out_status_next = status;
            out_valid_next  = 1'b1;
            acc_next        = '0;
            radix_next      = {{(ACC_W-1){1'b0}}, 1'b1};
            count_next      = '0;
            n_seen_next     = 1'b0;
            bad_next        = 1'b0;
            too_long_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            acc_reg       <= '0;
            radix_reg     <= {{(ACC_W-1){1'b0}}, 1'b1};
            count_reg     <= '0;
            n_seen_reg    <= 1'b0;
            bad_reg       <= 1'b0;
            too_long_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            acc_reg       <= acc_next;
            radix_reg     <= radix_next;
            count_reg     <= count_next;
            n_seen_reg    <= n_seen_next;
            bad_reg       <= bad_next;
            too_long_reg  <= too_long_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        out_data_reg   <= out_data_next;
        out_status_reg <= out_status_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_status_reg;

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        pop && head_entry.last |=> count_reg == '0 && !n_seen_reg && !too_long_reg)
        else $error("key state not cleared after last beat");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && head_entry.last) && count_reg != COUNT_MAX |=>
            count_reg == $past(count_reg) || count_reg == $past(count_reg) + 5'd1)
        else $error("character count jumped");
    a_flag_matches: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == STATUS_OK |-> m_tdata[N_FLAG_BIT] == m_tdata[N_FLAG_BIT+1])
        else $error("N flag bit and had_n disagree");
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != STATUS_OK |-> m_tdata == '0)
        else $error("error result carries a value");

endmodule

/* src/base24_key_to_binary.sv */
// Top level of the base-24 product key decoder: front classifier, queue and accumulator.
// Depends on b24k_pkg, b24k_front, b24k_queue and b24k_back.
//
// Usage:
//   Input stream: one key character per beat, ASCII in s_tdata[7:0], s_tlast on
//   the final character of a key. Dashes are skipped, a..z fold to upper case.
//   Output stream: one result beat per key, issued for the beat carrying s_tlast.
//   m_tdata holds the decoded value (bits 115..0, bit 115 set when an N was seen)
//   and had_n; m_tuser holds the status (ok, wrong length, invalid character).
//   An error result carries an all-zero m_tdata.
// Throughput: one character per cycle, sustained, across key boundaries, unless a
//   last beat waits on a result register held by low m_tready. Per character the back
//   end computes two multiplies by 24 and one radix-by-count product, combinationally.
// Result path: with the queue empty ahead of it, the last character accepted is first
//   stored in the queue, then graded into the result register that drives m_tvalid.
// Stalls: the result register holds while m_tready is low; characters of the next
//   key keep flowing until a further last beat needs the register, then the
//   two-entry queue fills and s_tready drops.
// Reset: rst_n clears the accumulator, counters and flags, empties the queue and
//   drops m_tvalid; the empty queue leaves s_tready high, so characters are accepted after reset.
module base24_key_to_binary #(
    parameter int unsigned VALUE_BYTES = b24k_pkg::VALUE_BYTES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // [7:0] key_char
    input  logic                                s_tlast,   // last_char
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [63:0] value_low, [115:64] value_high, [116] had_n, [119:117] zero
    output logic [b24k_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic [b24k_pkg::STATUS_W-1:0]       m_tuser    // [1:0] status
);
    import b24k_pkg::*;

    logic        q_full;
    logic        q_push;
    char_entry_t q_in;
    logic        q_pop;
    logic        q_valid;
    char_entry_t q_head;

    // Classify incoming beats
    b24k_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (q_in)
    );

    // Decouple front and back
    b24k_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_entry (q_head)
    );

    // Accumulate and deliver results
    b24k_back #(
        .VALUE_BYTES (VALUE_BYTES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_valid),
        .head_entry (q_head),
        .pop        (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule
